>>> rtl/alle_pkg.sv
`default_nettype none
package alle_pkg;

    localparam int ENTRIES   = 8;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LINK_BITS = $clog2(ENTRIES + 1);

    localparam logic [LINK_BITS-1:0] LINK_NIL = LINK_BITS'(ENTRIES);

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic    load;
        logic    insert;
        logic    walk_init;
        logic    step;
        logic    unlink;
        logic    res_write;
        t_status res_status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic op_delete;
        logic full;
        logic nonempty;
        logic cur_nil;
        logic key_match;
        logic walk_last;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/alle_ctrl.sv
`default_nettype none
module alle_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    input  wire alle_pkg::t_stat i_stat,
    output alle_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_UNLINK,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_status = alle_pkg::ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.op_delete) begin
                    o_cmd.res_write = 1'b1;
                    n_state         = S_RESP;
                    if (i_stat.full) begin
                        o_cmd.res_status = alle_pkg::ST_FULL;
                    end else begin
                        o_cmd.insert     = 1'b1;
                        o_cmd.res_status = alle_pkg::ST_DONE;
                    end
                end else if (!i_stat.nonempty) begin
                    o_cmd.res_write  = 1'b1;
                    o_cmd.res_status = alle_pkg::ST_EMPTY;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_WALK: begin
                if (!i_stat.cur_nil && i_stat.key_match) begin
                    n_state = S_UNLINK;
                end else if (i_stat.cur_nil || i_stat.walk_last) begin
                    o_cmd.res_write  = 1'b1;
                    o_cmd.res_status = alle_pkg::ST_NOT_FOUND;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_UNLINK: begin
                o_cmd.unlink     = 1'b1;
                o_cmd.res_write  = 1'b1;
                o_cmd.res_status = alle_pkg::ST_DONE;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

>>> rtl/alle_dp.sv
`default_nettype none
module alle_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_opcode,
    input  wire logic [31:0]    i_key_value,
    input  wire alle_pkg::t_cmd i_cmd,
    output alle_pkg::t_stat     o_stat,
    output logic [1:0]          o_status,
    output logic [2:0]          o_slot_index
);

    localparam int EN = alle_pkg::ENTRIES;
    localparam int KB = alle_pkg::KEY_BITS;
    localparam int SB = alle_pkg::SLOT_BITS;
    localparam int LB = alle_pkg::LINK_BITS;

    logic [KB-1:0] r_key_store [EN];
    logic [LB-1:0] r_next_link [EN];
    logic [LB-1:0] r_prev_link [EN];
    logic [EN-1:0] r_slot_used;
    logic [SB-1:0] r_tail_slot;
    logic          r_nonempty;

    logic          r_op;
    logic [KB-1:0] r_key;
    logic [LB-1:0] r_cur;
    logic [LB-1:0] r_steps;

    alle_pkg::t_status r_res_status;
    logic [SB-1:0]     r_res_slot;
    logic [1:0]        r_out_status;
    logic [2:0]        r_out_slot;

    logic [KB+31:0] key_ext;
    logic [SB-1:0]  free_slot;
    logic           cur_nil;
    logic [SB-1:0]  cur_slot;
    logic [LB-1:0]  cur_prev;
    logic [LB-1:0]  cur_next;
    logic           prev_ok;
    logic           next_ok;
    logic           tail_ok;
    logic [SB-1:0]  res_slot;
    logic [SB+2:0]  out_ext;

    assign key_ext = {{KB{i_key_value[31]}}, i_key_value};

    always_comb begin
        free_slot = '0;
        for (int i = EN - 1; i >= 0; i--) begin
            if (!r_slot_used[i]) begin
                free_slot = SB'(i);
            end
        end
    end

    assign cur_nil  = (r_cur >= alle_pkg::LINK_NIL);
    assign cur_slot = cur_nil ? '0 : r_cur[SB-1:0];
    assign cur_prev = r_prev_link[cur_slot];
    assign cur_next = r_next_link[cur_slot];
    assign prev_ok  = (cur_prev < alle_pkg::LINK_NIL);
    assign next_ok  = (cur_next < alle_pkg::LINK_NIL);
    assign tail_ok  = (LB'(r_tail_slot) < alle_pkg::LINK_NIL);

    assign o_stat.op_delete = r_op;
    assign o_stat.full      = &r_slot_used;
    assign o_stat.nonempty  = r_nonempty;
    assign o_stat.cur_nil   = cur_nil;
    assign o_stat.key_match = (r_key_store[cur_slot] == r_key);
    assign o_stat.walk_last = (r_steps == LB'(EN));

    assign res_slot = (i_cmd.res_status != alle_pkg::ST_DONE) ? '0 :
                      (i_cmd.insert ? free_slot : cur_slot);
    assign out_ext  = (SB + 3)'(r_res_slot);

    // link and occupancy state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < EN; i++) begin
                r_next_link[i] <= alle_pkg::LINK_NIL;
            end
            r_slot_used <= '0;
            r_tail_slot <= '0;
            r_nonempty  <= 1'b0;
        end else if (i_cmd.insert) begin
            r_slot_used[free_slot] <= 1'b1;
            r_next_link[free_slot] <= alle_pkg::LINK_NIL;
            if (r_nonempty && tail_ok) begin
                r_next_link[r_tail_slot] <= LB'(free_slot);
            end
            r_tail_slot <= free_slot;
            r_nonempty  <= 1'b1;
        end else if (i_cmd.unlink) begin
            if (cur_slot == r_tail_slot) begin
                if (prev_ok) begin
                    r_tail_slot <= cur_prev[SB-1:0];
                end else begin
                    r_tail_slot <= '0;
                    r_nonempty  <= 1'b0;
                end
            end
            if (prev_ok) begin
                r_next_link[cur_prev[SB-1:0]] <= cur_next;
            end
            r_next_link[cur_slot] <= alle_pkg::LINK_NIL;
            r_slot_used[cur_slot] <= 1'b0;
        end
    end

    // keys, back links, walk and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_key <= key_ext[KB-1:0];
        end
        if (i_cmd.insert) begin
            r_key_store[free_slot] <= r_key;
            if (r_nonempty && tail_ok) begin
                r_prev_link[free_slot] <= LB'(r_tail_slot);
            end else begin
                r_prev_link[free_slot] <= alle_pkg::LINK_NIL;
            end
        end
        if (i_cmd.unlink) begin
            if (next_ok) begin
                r_prev_link[cur_next[SB-1:0]] <= cur_prev;
            end
            r_prev_link[cur_slot] <= alle_pkg::LINK_NIL;
        end
        if (i_cmd.walk_init) begin
            r_cur   <= LB'(r_tail_slot);
            r_steps <= '0;
        end else if (i_cmd.step) begin
            r_cur   <= cur_prev;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.res_write) begin
            r_res_status <= i_cmd.res_status;
            r_res_slot   <= res_slot;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= out_ext[2:0];
        end
    end

    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;

`ifndef SYNTHESIS
    a_empty_no_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonempty == (|r_slot_used))
        else $error("list flag disagrees with used slots");

    a_tail_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonempty |-> r_slot_used[r_tail_slot])
        else $error("tail slot not in use");

    a_unlink_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.unlink |=> !r_slot_used[$past(cur_slot)])
        else $error("deleted slot still in use");

    a_insert_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> (r_tail_slot == $past(free_slot)) && r_nonempty)
        else $error("insert did not move tail");
`endif

endmodule
`default_nettype wire

>>> rtl/array_linked_list_engine.sv
// insert, empty-list delete: EXEC writes the result, RESP moves it to the output
// delete: EXEC, backward walk from tail at one slot per cycle, UNLINK on a hit, RESP
// a new word is taken only in IDLE, after RESP has passed its result to the output
// a new word is taken while the previous result word still waits on the output
// reset: synchronous active low; clears used bits, next links, tail and list flag
`default_nettype none
module array_linked_list_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_key_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [2:0]       o_slot_index
);

    alle_pkg::t_cmd  cmd;
    alle_pkg::t_stat stat;

    alle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    alle_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_opcode),
        .i_key_value  (i_key_value),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import alle_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int QUIET_TAIL     = 150;
    localparam int RANDOM_OPS     = 1930;
    localparam int HOLD_CYCLES    = 60;

    typedef struct {
        t_opcode     op;
        logic [31:0] key;
    } t_list_op;

    typedef struct {
        t_status    status;
        logic [2:0] slot;
    } t_reply;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        opcode = 1'b0;
    logic [31:0] key_value = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  status;
    logic [2:0]  slot_index;

    t_list_op ops_todo[$];
    t_reply   owed_replies[$];

    // shadow copy of the list
    logic [31:0]          key_copy[ENTRIES];
    logic [LINK_BITS-1:0] next_copy[ENTRIES];
    logic [LINK_BITS-1:0] prev_copy[ENTRIES];
    logic                 used_copy[ENTRIES];
    logic [SLOT_BITS-1:0] tail_copy;
    logic                 nonempty_copy;

    int  errors = 0;
    int  words_in = 0;
    int  idle_cycles = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  hold_left = 0;
    int  holds_done = 0;
    bit  in_taken = 0;
    bit  quiet = 0;

    array_linked_list_engine dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_key_value  (key_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (status),
        .o_slot_index (slot_index)
    );

    always #1 clk = ~clk;

    task automatic list_apply(input t_opcode op, input logic [31:0] key, output t_reply r);
        int                   free_slot;
        logic [LINK_BITS-1:0] cur;
        logic [LINK_BITS-1:0] p;
        logic [LINK_BITS-1:0] n;
        bit                   found;
        r.status = ST_DONE;
        r.slot   = '0;
        if (op == OP_INSERT) begin
            free_slot = ENTRIES;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!used_copy[i]) begin
                    free_slot = i;
                    break;
                end
            end
            if (free_slot == ENTRIES) begin
                r.status = ST_FULL;
            end else begin
                used_copy[free_slot] = 1'b1;
                key_copy[free_slot]  = key;
                next_copy[free_slot] = LINK_NIL;
                if (nonempty_copy) begin
                    prev_copy[free_slot] = LINK_BITS'(tail_copy);
                    next_copy[tail_copy] = LINK_BITS'(free_slot);
                end else begin
                    prev_copy[free_slot] = LINK_NIL;
                end
                tail_copy     = SLOT_BITS'(free_slot);
                nonempty_copy = 1'b1;
                r.slot        = 3'(free_slot);
            end
        end else if (!nonempty_copy) begin
            r.status = ST_EMPTY;
        end else begin
            cur   = LINK_BITS'(tail_copy);
            found = 0;
            for (int s = 0; s < ENTRIES; s++) begin
                if (cur >= ENTRIES) break;
                if (key_copy[cur] == key) begin
                    found = 1;
                    break;
                end
                cur = prev_copy[cur];
            end
            if (!found) begin
                r.status = ST_NOT_FOUND;
            end else begin
                p = prev_copy[cur];
                n = next_copy[cur];
                if (cur == LINK_BITS'(tail_copy)) begin
                    if (p < ENTRIES) begin
                        tail_copy = SLOT_BITS'(p);
                    end else begin
                        tail_copy     = '0;
                        nonempty_copy = 1'b0;
                    end
                end
                if (p < ENTRIES) next_copy[p] = n;
                if (n < ENTRIES) prev_copy[n] = p;
                next_copy[cur] = LINK_NIL;
                prev_copy[cur] = LINK_NIL;
                used_copy[cur] = 1'b0;
                r.slot         = 3'(cur);
            end
        end
    endtask

    task automatic add_op(input t_opcode op, input logic [31:0] key);
        t_list_op item;
        item.op  = op;
        item.key = key;
        ops_todo.push_back(item);
    endtask

    // sender
    always @(negedge clk) begin
        t_list_op item;
        quiet = (ops_todo.size() < QUIET_TAIL);
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_taken = 0;
        end else if (!in_valid || in_taken) begin
            in_taken = 0;
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (ops_todo.size() == 0) begin
                in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 3);
                in_valid <= 1'b0;
            end else begin
                item = ops_todo.pop_front();
                in_valid  <= 1'b1;
                opcode    <= item.op;
                key_value <= item.key;
            end
        end
    end

    // receiver, with a long hold-off now and then so the engine backs up
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (holds_done < 2 && words_in >= 500 + 800 * holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // accept words, predict and check
    always @(posedge clk) begin
        t_reply r;
        t_reply want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                list_apply(t_opcode'(opcode), key_value, r);
                owed_replies.push_back(r);
                in_taken = 1;
                words_in++;
            end
            if (out_valid && !out_stall) begin
                if (owed_replies.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected word: status %0d slot %0d", status, slot_index);
                    errors++;
                end else begin
                    want = owed_replies.pop_front();
                    if (status !== want.status || slot_index !== want.slot) begin
                        if (errors < 10)
                            $display("mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                                     want.status, status, want.slot, slot_index);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [31:0] key_pool[12];
        int          insert_pct;
        logic [31:0] k;

        for (int i = 0; i < ENTRIES; i++) begin
            key_copy[i]  = '0;
            next_copy[i] = LINK_NIL;
            prev_copy[i] = LINK_NIL;
            used_copy[i] = 1'b0;
        end
        tail_copy     = '0;
        nonempty_copy = 1'b0;

        // empty list, fill up, overflow, duplicates, tail and head removal
        add_op(OP_DELETE, 32'h0000_0000);
        add_op(OP_INSERT, 32'h8000_0000);
        add_op(OP_INSERT, 32'h7fff_ffff);
        add_op(OP_INSERT, 32'h0000_0000);
        add_op(OP_INSERT, 32'hffff_ffff);
        add_op(OP_INSERT, 32'h0000_0005);
        add_op(OP_INSERT, 32'h0000_0005);
        add_op(OP_INSERT, 32'h0000_0001);
        add_op(OP_INSERT, 32'h0000_0002);
        add_op(OP_INSERT, 32'h0000_0003);
        add_op(OP_DELETE, 32'h0001_2345);
        add_op(OP_DELETE, 32'h0000_0005);
        add_op(OP_DELETE, 32'h0000_0002);
        add_op(OP_DELETE, 32'h8000_0000);
        add_op(OP_INSERT, 32'h0000_0009);
        add_op(OP_DELETE, 32'h0000_0009);
        add_op(OP_DELETE, 32'h0000_0005);
        add_op(OP_DELETE, 32'h7fff_ffff);
        add_op(OP_DELETE, 32'h0000_0000);
        add_op(OP_DELETE, 32'hffff_ffff);
        add_op(OP_DELETE, 32'h0000_0001);
        add_op(OP_DELETE, 32'h0000_0001);

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 12; i++) key_pool[i] = $urandom;

        insert_pct = 50;
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i % 120 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 25;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            if ($urandom_range(0, 99) < 80)
                k = key_pool[$urandom_range(0, 11)];
            else
                k = $urandom;
            add_op(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE, k);
        end

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (ops_todo.size() != 0 || in_valid || owed_replies.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 12) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
